FILE: design/vrdc_pkg.sv
// Shared types and constants for the valid-region diagonal corner tracker.
`timescale 1ns / 1ps

package vrdc_pkg;

    localparam int COORD_W = 12;   // pixel column / row
    localparam int SIZE_W  = 13;   // frame size register
    localparam int KEY_W   = 15;   // signed row+col or row-col, also holds cols+rows
    localparam int INDEX_W = 8;    // config register index

    localparam logic [SIZE_W-1:0] FRAME_SIZE_RESET = SIZE_W'(4096);

    typedef enum logic [INDEX_W-1:0] {
        CFG_FRAME_COLS = 8'd0,
        CFG_FRAME_ROWS = 8'd1
    } cfg_index_t;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } pos_t;

    typedef logic signed [KEY_W-1:0] key_t;

endpackage

FILE: design/vrdc_tracker.sv
// One running extreme (min or max of a diagonal key) with its pixel position.
`timescale 1ns / 1ps

module vrdc_tracker (
    input  logic          aclk,
    input  logic          seek_max,     // 1: strict greater wins, 0: strict less wins
    input  logic          load,         // reload from frame defaults (wins over sample)
    input  vrdc_pkg::key_t load_key,
    input  vrdc_pkg::pos_t load_pos,
    input  logic          sample_en,
    input  vrdc_pkg::key_t sample_key,
    input  vrdc_pkg::pos_t sample_pos,
    output vrdc_pkg::pos_t pos_next     // position after this sample, before reload
);
    import vrdc_pkg::*;

    key_t key_reg;
    pos_t pos_reg;
    key_t key_next;
    logic better;

    always_comb begin
        if (seek_max) begin
            better = sample_key > key_reg;
        end else begin
            better = sample_key < key_reg;
        end
        key_next = key_reg;
        pos_next = pos_reg;
        if (sample_en && better) begin
            key_next = sample_key;
            pos_next = sample_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            key_reg <= load_key;
            pos_reg <= load_pos;
        end else begin
            key_reg <= key_next;
            pos_reg <= pos_next;
        end
    end

endmodule

FILE: design/valid_region_diagonal_corners.sv
// Top level of the valid-region diagonal corner tracker.
`timescale 1ns / 1ps

// Takes one pixel request per clock (column and row in s_tdata, valid flag in
// s_tuser, end of frame in s_tlast) and keeps four running corner extremes:
// least and greatest row+col, least and greatest row-col; ties keep the
// earliest pixel. Every pixel is done in the cycle it is accepted, so the
// block sustains one pixel per clock; the only stall is when a finished
// corner result still sits unread in the output register and another pixel
// arrives. On the last pixel of a frame the four corners (after that pixel)
// go to the output register in the next cycle and the trackers reload to the
// frame corners. Any config write, whatever its index, restarts the frame;
// sizes are clamped to 1..min(MAX_DIM, 8191). The config port is always ready.
module valid_region_diagonal_corners #(
    parameter int MAX_DIM = 4096
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // pixel stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // pixel_col[11:0], pixel_row[23:12]
    input  logic [0:0]                  s_tuser,   // pixel_valid[0]
    input  logic                        s_tlast,   // frame_last
    // corner results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // lower_left_col[11:0], lower_left_row[23:12], lower_right_col[35:24],
    // lower_right_row[47:36], upper_left_col[59:48], upper_left_row[71:60],
    // upper_right_col[83:72], upper_right_row[95:84]
    output logic [95:0]                 m_tdata,
    // register writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [vrdc_pkg::INDEX_W-1:0] cfg_index,
    input  logic [vrdc_pkg::SIZE_W-1:0] cfg_data
);
    import vrdc_pkg::*;

    localparam int SIZE_MAX = (1 << SIZE_W) - 1;
    localparam logic [SIZE_W-1:0] SIZE_CAP =
        SIZE_W'((MAX_DIM > SIZE_MAX) ? SIZE_MAX : MAX_DIM);

    logic [SIZE_W-1:0] frame_cols_reg, frame_cols_next;
    logic [SIZE_W-1:0] frame_rows_reg, frame_rows_next;
    logic              m_tvalid_reg;
    logic [95:0]       m_tdata_reg;

    logic              in_fire, cfg_fire, reload;
    logic [SIZE_W-1:0] cols_c, rows_c;
    logic [COORD_W-1:0] col_max, row_max;
    key_t              size_sum, pix_sum, pix_diff;
    pos_t              pix_pos;
    pos_t              ll_pos, lr_pos, ul_pos, ur_pos;
    pos_t              ll_load, lr_load, ul_load, ur_load;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // frame size registers; reset value flows through _next so trackers load it too
    always_comb begin
        frame_cols_next = frame_cols_reg;
        frame_rows_next = frame_rows_reg;
        if (!aresetn) begin
            frame_cols_next = FRAME_SIZE_RESET;
            frame_rows_next = FRAME_SIZE_RESET;
        end else if (cfg_fire) begin
            unique case (cfg_index)
                CFG_FRAME_COLS: frame_cols_next = cfg_data;
                CFG_FRAME_ROWS: frame_rows_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        frame_cols_reg <= frame_cols_next;
        frame_rows_reg <= frame_rows_next;
    end

    // frame defaults
    always_comb begin
        if (frame_cols_next == '0) begin
            cols_c = SIZE_W'(1);
        end else if (frame_cols_next > SIZE_CAP) begin
            cols_c = SIZE_CAP;
        end else begin
            cols_c = frame_cols_next;
        end
        if (frame_rows_next == '0) begin
            rows_c = SIZE_W'(1);
        end else if (frame_rows_next > SIZE_CAP) begin
            rows_c = SIZE_CAP;
        end else begin
            rows_c = frame_rows_next;
        end
    end

    assign col_max  = COORD_W'(cols_c - SIZE_W'(1));
    assign row_max  = COORD_W'(rows_c - SIZE_W'(1));
    assign size_sum = key_t'({2'b00, cols_c} + {2'b00, rows_c});

    assign ll_load = '{row: '0,      col: '0};
    assign lr_load = '{row: '0,      col: col_max};
    assign ul_load = '{row: row_max, col: '0};
    assign ur_load = '{row: row_max, col: col_max};

    assign reload = !aresetn || cfg_fire || (in_fire && s_tlast);

    // pixel keys
    assign pix_pos.col = s_tdata[COORD_W-1:0];
    assign pix_pos.row = s_tdata[2*COORD_W-1:COORD_W];
    assign pix_sum  = key_t'({3'b000, pix_pos.row} + {3'b000, pix_pos.col});
    assign pix_diff = key_t'({3'b000, pix_pos.row} - {3'b000, pix_pos.col});

    vrdc_tracker u_lower_left (
        .aclk(aclk), .seek_max(1'b0), .load(reload),
        .load_key(size_sum), .load_pos(ll_load),
        .sample_en(in_fire && s_tuser[0]), .sample_key(pix_sum), .sample_pos(pix_pos),
        .pos_next(ll_pos)
    );

    vrdc_tracker u_lower_right (
        .aclk(aclk), .seek_max(1'b0), .load(reload),
        .load_key(size_sum), .load_pos(lr_load),
        .sample_en(in_fire && s_tuser[0]), .sample_key(pix_diff), .sample_pos(pix_pos),
        .pos_next(lr_pos)
    );

    vrdc_tracker u_upper_left (
        .aclk(aclk), .seek_max(1'b1), .load(reload),
        .load_key('0), .load_pos(ul_load),
        .sample_en(in_fire && s_tuser[0]), .sample_key(pix_diff), .sample_pos(pix_pos),
        .pos_next(ul_pos)
    );

    vrdc_tracker u_upper_right (
        .aclk(aclk), .seek_max(1'b1), .load(reload),
        .load_key('0), .load_pos(ur_load),
        .sample_en(in_fire && s_tuser[0]), .sample_key(pix_sum), .sample_pos(pix_pos),
        .pos_next(ur_pos)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_fire && s_tlast) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && s_tlast) begin
            m_tdata_reg <= {ur_pos, ul_pos, lr_pos, ll_pos};
        end
    end

endmodule

FILE: design/vrdc_checker.sv
// Port-level checks for the corner tracker, bound to the top level.
`timescale 1ns / 1ps

module vrdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // end of frame always produces a result next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("frame end without result");

    // a new result only follows an end-of-frame request
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result without frame end");

    // no pixel is refused while the output side has room
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind valid_region_diagonal_corners vrdc_checker u_vrdc_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);
